[rtl/core/sts_pkg.sv]
`timescale 1ns / 1ps

package sts_pkg;

    // Number of result slots that one source byte can produce.
    localparam int unsigned MAX_TOKENS = 3;

    typedef enum logic [1:0] {
        MODE_IDLE = 2'd0,
        MODE_NAME = 2'd1,
        MODE_NUM  = 2'd2
    } mode_t;

    typedef enum logic [2:0] {
        KIND_SEMI   = 3'd0,
        KIND_NUMBER = 3'd1,
        KIND_VAR    = 3'd2,
        KIND_PRINT  = 3'd3,
        KIND_SINGLE = 3'd4,
        KIND_DOUBLE = 3'd5
    } kind_t;

    typedef struct packed {
        logic [7:0] src_byte;
        logic       end_of_source;
    } in_item_t;

    typedef struct packed {
        kind_t       token_kind;
        logic [15:0] token_start;
        logic [15:0] token_length;
        logic [7:0]  op_first;
        logic [7:0]  op_second;
        logic        run_last;
    } out_item_t;

    // All tokens caused by one source byte, oldest in slot zero.
    typedef struct packed {
        out_item_t [MAX_TOKENS-1:0] tok;
        logic [1:0]                 count;
    } tok_bundle_t;

endpackage

[rtl/core/script_token_scanner_top.sv]
`timescale 1ns / 1ps

// Channel   Direction  Handshake           Payload
// item      in         push / full         src_byte, end_of_source
// token     out        pop / empty         token_kind .. run_last
//
// One source byte is taken per cycle while full is low; the scanner classifies
// it in that cycle. Each byte yields zero to three tokens, and the output side
// gives one token per cycle while pop is high and the queue is not empty.
// A queue of QUEUE_DEPTH token bundles sits between scanner and output; full
// rises when it holds that many unread bundles.
// Reset is asynchronous and needs no clearing pass; the first byte after it,
// or after an end of source, is at position zero.
module script_token_scanner_top
    import sts_pkg::*;
#(
    parameter int POS_BITS    = 16,
    parameter int QUEUE_DEPTH = 4
)
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      push,
    input  in_item_t  item,
    output logic      full,
    input  logic      pop,
    output logic      empty,
    output out_item_t token
);

    tok_bundle_t bundle;
    tok_bundle_t head;
    logic        bundle_valid;
    logic        accept;
    logic        q_empty;
    logic        q_rd;

    assign accept = push && !full;

    sts_front #(
        .POS_BITS(POS_BITS)
    ) u_front (
        .clk         (clk),
        .rst_n       (rst_n),
        .accept      (accept),
        .item        (item),
        .bundle      (bundle),
        .bundle_valid(bundle_valid)
    );

    sts_queue #(
        .DEPTH(QUEUE_DEPTH)
    ) u_queue (
        .clk    (clk),
        .rst_n  (rst_n),
        .wr_en  (accept && bundle_valid),
        .wr_data(bundle),
        .rd_en  (q_rd),
        .head   (head),
        .full   (full),
        .q_empty(q_empty)
    );

    sts_back u_back (
        .clk    (clk),
        .rst_n  (rst_n),
        .head   (head),
        .q_empty(q_empty),
        .q_rd   (q_rd),
        .pop    (pop),
        .empty  (empty),
        .token  (token)
    );

endmodule

[rtl/core/sts_front.sv]
`timescale 1ns / 1ps

module sts_front
    import sts_pkg::*;
#(
    parameter int POS_BITS = 16
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        accept,
    input  in_item_t    item,
    output tok_bundle_t bundle,
    output logic        bundle_valid
);

    localparam logic [POS_BITS-1:0] POS_MAX = '1;
    localparam logic [15:0]         LEN_MAX = 16'hFFFF;
    localparam logic [2:0]          KP_DONE = 3'd5;
    localparam logic [2:0]          KP_MISS = 3'd7;
    localparam int                  NCAND   = 6;

    mode_t               mode_reg, mode_next;
    logic [7:0]          held_b_reg, held_b_next;
    logic                held_v_reg, held_v_next;
    logic [POS_BITS-1:0] start_reg, start_next;
    logic [15:0]         len_reg, len_next;
    logic [2:0]          kp_reg, kp_next;
    logic [POS_BITS-1:0] bpos_reg, bpos_next;

    out_item_t [NCAND-1:0] cand;
    logic [NCAND-1:0]      cand_v;
    logic                  done;
    logic                  cont;
    logic [1:0]            n;
    logic [7:0]            c;

    function automatic logic is_name(input logic [7:0] ch);
        is_name = (ch >= "a" && ch <= "z") || (ch >= "A" && ch <= "Z") ||
                  ch == "_" || ch == "$";
    endfunction

    function automatic logic is_digit(input logic [7:0] ch);
        is_digit = ch >= "0" && ch <= "9";
    endfunction

    function automatic logic is_num(input logic [7:0] ch);
        is_num = is_digit(ch) || ch == ".";
    endfunction

    function automatic logic is_single(input logic [7:0] ch);
        logic r;
        case (ch) inside
            "+", "*", "-", "/", "=", "!", "(", ")", "[", "]", ".", "%", "{", "}":
                r = 1'b1;
            default:
                r = 1'b0;
        endcase
        is_single = r;
    endfunction

    function automatic logic is_dfirst(input logic [7:0] ch);
        logic r;
        case (ch) inside
            "!", "=", "<", ">", "+", "-", "*", "/", "%":
                r = 1'b1;
            default:
                r = 1'b0;
        endcase
        is_dfirst = r;
    endfunction

    function automatic logic [7:0] kw_char(input logic [2:0] idx);
        logic [7:0] r;
        unique case (idx)
            3'd0:    r = "p";
            3'd1:    r = "r";
            3'd2:    r = "i";
            3'd3:    r = "n";
            3'd4:    r = "t";
            default: r = 8'h00;
        endcase
        kw_char = r;
    endfunction

    function automatic out_item_t make_tok(input kind_t kind,
                                           input logic [POS_BITS-1:0] start,
                                           input logic [15:0] len,
                                           input logic [7:0] a,
                                           input logic [7:0] b);
        out_item_t t;
        t.token_kind   = kind;
        t.token_start  = 16'(start);
        t.token_length = len;
        t.op_first     = a;
        t.op_second    = b;
        t.run_last     = 1'b0;
        make_tok = t;
    endfunction

    function automatic out_item_t run_tok(input mode_t mode,
                                          input logic [2:0] kp,
                                          input logic [POS_BITS-1:0] start,
                                          input logic [15:0] len);
        kind_t k;
        if (mode == MODE_NAME)
        begin
            k = (kp == KP_DONE) ? KIND_PRINT : KIND_VAR;
        end
        else
        begin
            k = KIND_NUMBER;
        end
        run_tok = make_tok(k, start, len, 8'h00, 8'h00);
    endfunction

    assign c = item.src_byte;

    always_comb
    begin
        cont = (mode_reg == MODE_NAME && (is_name(c) || is_num(c))) ||
               (mode_reg == MODE_NUM && is_num(c));

        mode_next   = mode_reg;
        held_b_next = held_b_reg;
        held_v_next = held_v_reg;
        start_next  = start_reg;
        len_next    = len_reg;
        kp_next     = kp_reg;
        cand_v      = '0;
        for (int k = 0; k < NCAND; k++)
        begin
            cand[k] = '0;
        end
        done = 1'b0;

        // A running name or number either grows or is closed off.
        if (mode_reg == MODE_NAME || mode_reg == MODE_NUM)
        begin
            if (cont)
            begin
                done = 1'b1;
                if (len_reg != LEN_MAX)
                begin
                    len_next = len_reg + 16'd1;
                end
                if (mode_reg == MODE_NAME)
                begin
                    if (kp_reg < KP_DONE && c == kw_char(kp_reg))
                    begin
                        kp_next = kp_reg + 3'd1;
                    end
                    else
                    begin
                        kp_next = KP_MISS;
                    end
                end
            end
            else
            begin
                cand_v[0] = 1'b1;
                cand[0]   = run_tok(mode_reg, kp_reg, start_reg, len_reg);
                mode_next = MODE_IDLE;
            end
        end
        else
        begin
            mode_next = MODE_IDLE;
        end

        // The held operator pairs with '=', goes out alone if it is a single-byte operator, or is dropped.
        if (!done && held_v_reg)
        begin
            held_v_next = 1'b0;
            if (c == "=")
            begin
                cand_v[1] = 1'b1;
                cand[1]   = make_tok(KIND_DOUBLE, start_reg, 16'd2, held_b_reg, c);
                done      = 1'b1;
            end
            else if (is_single(held_b_reg))
            begin
                cand_v[1] = 1'b1;
                cand[1]   = make_tok(KIND_SINGLE, start_reg, 16'd1, held_b_reg, 8'h00);
            end
        end

        if (!done)
        begin
            if (c == ";")
            begin
                cand_v[2] = 1'b1;
                cand[2]   = make_tok(KIND_SEMI, bpos_reg, 16'd1, 8'h00, 8'h00);
            end
            else if (is_name(c))
            begin
                mode_next  = MODE_NAME;
                start_next = bpos_reg;
                len_next   = 16'd1;
                kp_next    = (c == "p") ? 3'd1 : KP_MISS;
            end
            else if (is_dfirst(c))
            begin
                held_b_next = c;
                held_v_next = 1'b1;
                start_next  = bpos_reg;
            end
            else if (is_single(c))
            begin
                cand_v[2] = 1'b1;
                cand[2]   = make_tok(KIND_SINGLE, bpos_reg, 16'd1, c, 8'h00);
            end
            else if (is_digit(c))
            begin
                mode_next  = MODE_NUM;
                start_next = bpos_reg;
                len_next   = 16'd1;
                kp_next    = 3'd0;
            end
        end

        bpos_next = (bpos_reg == POS_MAX) ? bpos_reg : bpos_reg + 1'b1;

        // End of source flushes the open run and any held single-byte operator, appends
        // a semicolon and returns the scanner to its reset state.
        if (item.end_of_source)
        begin
            if (held_v_next && is_single(held_b_next))
            begin
                cand_v[3] = 1'b1;
                cand[3]   = make_tok(KIND_SINGLE, start_next, 16'd1, held_b_next, 8'h00);
            end
            if (mode_next != MODE_IDLE)
            begin
                cand_v[4] = 1'b1;
                cand[4]   = run_tok(mode_next, kp_next, start_next, len_next);
            end
            cand_v[5] = 1'b1;
            cand[5]   = make_tok(KIND_SEMI, bpos_next, 16'd1, 8'h00, 8'h00);

            mode_next   = MODE_IDLE;
            held_b_next = 8'h00;
            held_v_next = 1'b0;
            start_next  = '0;
            len_next    = 16'd0;
            kp_next     = 3'd0;
            bpos_next   = '0;
        end
    end

    // Pack the candidates, in order, into the bundle slots.
    always_comb
    begin
        bundle = '0;
        n      = 2'd0;
        for (int k = 0; k < NCAND; k++)
        begin
            if (cand_v[k] && n != 2'd3)
            begin
                bundle.tok[n] = cand[k];
                n             = n + 2'd1;
            end
        end
        for (int j = 0; j < MAX_TOKENS; j++)
        begin
            bundle.tok[j].run_last = (n == 2'(j + 1));
        end
        bundle.count = n;
        bundle_valid = n != 2'd0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg   <= MODE_IDLE;
            held_b_reg <= 8'h00;
            held_v_reg <= 1'b0;
            start_reg  <= '0;
            len_reg    <= 16'd0;
            kp_reg     <= 3'd0;
            bpos_reg   <= '0;
        end
        else if (accept)
        begin
            mode_reg   <= mode_next;
            held_b_reg <= held_b_next;
            held_v_reg <= held_v_next;
            start_reg  <= start_next;
            len_reg    <= len_next;
            kp_reg     <= kp_next;
            bpos_reg   <= bpos_next;
        end
    end

    // An operator is only held while no name or number is running.
    a_held_idle: assert property (@(posedge clk) disable iff (!rst_n)
        held_v_reg |-> mode_reg == MODE_IDLE)
        else $error("operator held while a run is open");

    // The end of source always yields a bundle that closes with a semicolon.
    a_eos_semi: assert property (@(posedge clk) disable iff (!rst_n)
        accept && item.end_of_source |->
            bundle_valid && bundle.tok[bundle.count - 2'd1].token_kind == KIND_SEMI)
        else $error("end of source without closing semicolon");

endmodule

[rtl/core/sts_queue.sv]
`timescale 1ns / 1ps

module sts_queue
    import sts_pkg::*;
#(
    parameter int DEPTH = 4
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        wr_en,
    input  tok_bundle_t wr_data,
    input  logic        rd_en,
    output tok_bundle_t head,
    output logic        full,
    output logic        q_empty
);

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);
    localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(DEPTH - 1);
    localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(DEPTH);

    tok_bundle_t      mem_reg [DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg, rd_ptr_reg;
    logic [CNT_W-1:0] cnt_reg;

    assign head    = mem_reg[rd_ptr_reg];
    assign full    = cnt_reg == CNT_FULL;
    assign q_empty = cnt_reg == '0;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem_reg[wr_ptr_reg] <= wr_data;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            cnt_reg    <= '0;
        end
        else
        begin
            if (wr_en)
            begin
                wr_ptr_reg <= (wr_ptr_reg == PTR_LAST) ? '0 : wr_ptr_reg + 1'b1;
            end
            if (rd_en)
            begin
                rd_ptr_reg <= (rd_ptr_reg == PTR_LAST) ? '0 : rd_ptr_reg + 1'b1;
            end
            if (wr_en && !rd_en)
            begin
                cnt_reg <= cnt_reg + 1'b1;
            end
            else if (rd_en && !wr_en)
            begin
                cnt_reg <= cnt_reg - 1'b1;
            end
        end
    end

    a_no_overrun: assert property (@(posedge clk) disable iff (!rst_n)
        wr_en && !rd_en |-> !full)
        else $error("queue written while full");

endmodule

[rtl/core/sts_back.sv]
`timescale 1ns / 1ps

module sts_back
    import sts_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  tok_bundle_t head,
    input  logic        q_empty,
    output logic        q_rd,
    input  logic        pop,
    output logic        empty,
    output out_item_t   token
);

    logic [1:0] idx_reg, idx_next;
    logic       last_slot;

    assign empty     = q_empty;
    assign token     = head.tok[idx_reg];
    assign last_slot = idx_reg == head.count - 2'd1;
    assign q_rd      = pop && !q_empty && last_slot;

    always_comb
    begin
        idx_next = idx_reg;
        if (pop && !q_empty)
        begin
            idx_next = last_slot ? 2'd0 : idx_reg + 2'd1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            idx_reg <= 2'd0;
        end
        else
        begin
            idx_reg <= idx_next;
        end
    end

    // A queued bundle is never empty and the slot index stays inside it.
    a_idx_range: assert property (@(posedge clk) disable iff (!rst_n)
        !q_empty |-> head.count != 2'd0 && idx_reg < head.count)
        else $error("slot index outside the head bundle");

endmodule
